// ----- src/cseg_pkg.sv -----
package cseg_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS   = 2'd2;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = 2;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- src/circle_segment_intersect_test.sv -----
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
// in       in         in_valid/in_ready      in_start_x, in_start_y, in_end_x, in_end_y
// out      out        out_valid/out_ready    out_hit, out_degenerate
//
// One segment per cycle is accepted while in_ready is high; each result passes through the
// queue and then the six-stage multiply and compare pipeline in the back part.
// A synchronous active-low reset clears the queue, the pipeline valid bits and the
// configuration registers. A stalled output holds the back part; the four-entry queue
// then absorbs input until it fills and in_ready drops. Configuration is always ready.
module circle_segment_intersect_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cseg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        in_start_x,
  input  logic signed [COORD_BITS-1:0]        in_start_y,
  input  logic signed [COORD_BITS-1:0]        in_end_x,
  input  logic signed [COORD_BITS-1:0]        in_end_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic                                out_degenerate
);

  localparam int IW = 6 * (COORD_BITS + 1) + 1;

  logic [IW-1:0] push_item, pop_item;
  logic [COORD_BITS-2:0] radius;
  logic take, pop;
  cseg_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_status.full;
  assign take      = in_valid && in_ready;

  cseg_front #(.N(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_take    (take),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .item       (push_item),
    .radius     (radius)
  );

  cseg_queue #(.WIDTH(IW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (push_item),
    .pop       (pop),
    .pop_data  (pop_item),
    .status    (q_status)
  );

  cseg_back #(.N(COORD_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .item           (pop_item),
    .radius         (radius),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_degenerate (out_degenerate)
  );

endmodule

// ----- src/cseg_queue.sv -----
module cseg_queue #(
  parameter int WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output cseg_pkg::q_status_t status
);

  logic [WIDTH-1:0] mem [cseg_pkg::QUEUE_DEPTH];
  logic [cseg_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [cseg_pkg::QUEUE_PTR_BITS:0] count_r, count_nxt;

  // Storage is written at the tail on every push.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  assign status.full  = (count_r == (cseg_pkg::QUEUE_PTR_BITS + 1)'(cseg_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

endmodule

// ----- src/cseg_front.sv -----
module cseg_front #(
  parameter int N = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cseg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [N-1:0]                        cfg_data,
  input  logic                                in_take,
  input  logic signed [N-1:0]                 in_start_x,
  input  logic signed [N-1:0]                 in_start_y,
  input  logic signed [N-1:0]                 in_end_x,
  input  logic signed [N-1:0]                 in_end_y,
  output logic [6*(N+1):0]                    item,
  output logic [N-2:0]                        radius
);

  localparam int D = N + 1;

  logic signed [N-1:0] center_x_r, center_y_r;
  logic [N-2:0] radius_r;
  logic signed [D-1:0] dx, dy, fx, fy, gx, gy;
  logic deg;

  // Configuration registers; writes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cseg_pkg::CFG_CENTER_X: center_x_r <= cfg_data;
        cseg_pkg::CFG_CENTER_Y: center_y_r <= cfg_data;
        cseg_pkg::CFG_RADIUS:   radius_r   <= cfg_data[N-2:0];
        default: ;
      endcase
    end
  end

  // Differences relative to the segment and the center, plus the zero-length check.
  assign dx = {in_start_x[N-1], in_start_x} - {in_end_x[N-1], in_end_x};
  assign dy = {in_start_y[N-1], in_start_y} - {in_end_y[N-1], in_end_y};
  assign fx = {in_end_x[N-1], in_end_x} - {center_x_r[N-1], center_x_r};
  assign fy = {in_end_y[N-1], in_end_y} - {center_y_r[N-1], center_y_r};
  assign gx = {in_start_x[N-1], in_start_x} - {center_x_r[N-1], center_x_r};
  assign gy = {in_start_y[N-1], in_start_y} - {center_y_r[N-1], center_y_r};
  assign deg = in_take && (in_start_x == in_end_x) && (in_start_y == in_end_y);

  assign item   = {deg, gy, gx, fy, fx, dy, dx};
  assign radius = radius_r;

endmodule

// ----- src/cseg_back.sv -----
module cseg_back #(
  parameter int N = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cseg_pkg::q_status_t q_status,
  input  logic [6*(N+1):0]    item,
  input  logic [N-2:0]        radius,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit,
  output logic                out_degenerate
);

  localparam int D = N + 1;     // difference width
  localparam int P = 2 * D;     // product width
  localparam int E = P + 2;     // signed sum width
  localparam int L = D;         // split point for wide products
  localparam int R = 2 * (N - 1);

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic d1_r, d2_r, d3_r, d4_r, d5_r, out_degenerate_r, out_hit_r;

  logic signed [D-1:0] dx, dy, fx, fy, gx, gy;
  logic deg_in;

  // Stage 1 products.
  logic signed [P-1:0] sq_dx_r, sq_dy_r, pr_x_r, pr_y_r;
  logic signed [P-1:0] sq_fx_r, sq_fy_r, sq_gx_r, sq_gy_r;
  logic [R-1:0] rr_r;

  // Stage 2 quadratic terms.
  logic signed [E-1:0] a2_r, h2_r, c02_r, c12_r;
  logic signed [E-1:0] rr_ext, h_neg;

  // Stage 3 classification.
  logic early3_r, cond3_r;
  logic [P-1:0] hm3_r, a3_r, c3_r;
  logic early4_r, cond4_r, early5_r, cond5_r;

  // Stage 4 partial products.
  logic [P-1:0] hh4_r, hl4_r, hlo4_r, ahh4_r, ahl4_r, alh4_r, all4_r;

  // Stage 5 full products.
  logic [2*P-1:0] hsq5_r, acp5_r;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && !q_status.empty;

  assign {deg_in, gy, gx, fy, fx, dy, dx} = item;

  assign rr_ext = {{(E-R){1'b0}}, rr_r};
  assign h_neg  = -h2_r;

  // Pipeline registers; the whole back part moves together.
  always_ff @(posedge clk) begin
    if (en) begin
      sq_dx_r <= dx * dx;
      sq_dy_r <= dy * dy;
      pr_x_r  <= fx * dx;
      pr_y_r  <= fy * dy;
      sq_fx_r <= fx * fx;
      sq_fy_r <= fy * fy;
      sq_gx_r <= gx * gx;
      sq_gy_r <= gy * gy;
      rr_r    <= {{(R-(N-1)){1'b0}}, radius} * {{(R-(N-1)){1'b0}}, radius};
      d1_r    <= deg_in;

      a2_r  <= {{2{sq_dx_r[P-1]}}, sq_dx_r} + {{2{sq_dy_r[P-1]}}, sq_dy_r};
      h2_r  <= {{2{pr_x_r[P-1]}}, pr_x_r} + {{2{pr_y_r[P-1]}}, pr_y_r};
      c02_r <= {{2{sq_fx_r[P-1]}}, sq_fx_r} + {{2{sq_fy_r[P-1]}}, sq_fy_r} - rr_ext;
      c12_r <= {{2{sq_gx_r[P-1]}}, sq_gx_r} + {{2{sq_gy_r[P-1]}}, sq_gy_r} - rr_ext;
      d2_r  <= d1_r;

      // Endpoint on the circle, or the ends on opposite sides of it.
      early3_r <= (c02_r == '0) || (c12_r == '0) || (c02_r[E-1] != c12_r[E-1]);
      // Both ends outside and the vertex within the segment.
      cond3_r  <= !c02_r[E-1] && (c02_r != '0) && (h2_r[E-1] || (h2_r == '0)) &&
                  (h_neg <= a2_r);
      hm3_r    <= h_neg[P-1:0];
      a3_r     <= a2_r[P-1:0];
      c3_r     <= c02_r[P-1:0];
      d3_r     <= d2_r;

      hh4_r   <= {{L{1'b0}}, hm3_r[P-1:L]} * {{L{1'b0}}, hm3_r[P-1:L]};
      hl4_r   <= {{L{1'b0}}, hm3_r[P-1:L]} * {{L{1'b0}}, hm3_r[L-1:0]};
      hlo4_r  <= {{L{1'b0}}, hm3_r[L-1:0]} * {{L{1'b0}}, hm3_r[L-1:0]};
      ahh4_r  <= {{L{1'b0}}, a3_r[P-1:L]} * {{L{1'b0}}, c3_r[P-1:L]};
      ahl4_r  <= {{L{1'b0}}, a3_r[P-1:L]} * {{L{1'b0}}, c3_r[L-1:0]};
      alh4_r  <= {{L{1'b0}}, a3_r[L-1:0]} * {{L{1'b0}}, c3_r[P-1:L]};
      all4_r  <= {{L{1'b0}}, a3_r[L-1:0]} * {{L{1'b0}}, c3_r[L-1:0]};
      early4_r <= early3_r;
      cond4_r  <= cond3_r;
      d4_r     <= d3_r;

      hsq5_r <= {hh4_r, hlo4_r} + ({{P{1'b0}}, hl4_r} << (L + 1));
      acp5_r <= {ahh4_r, all4_r} + ({{P{1'b0}}, ahl4_r} << L) +
                ({{P{1'b0}}, alh4_r} << L);
      early5_r <= early4_r;
      cond5_r  <= cond4_r;
      d5_r     <= d4_r;

      // Tangent or secant test through the discriminant.
      out_hit_r        <= !d5_r && (early5_r || (cond5_r && (hsq5_r >= acp5_r)));
      out_degenerate_r <= d5_r;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_degenerate = out_degenerate_r;

endmodule

// ----- tb/tb_circle_segment_intersect_test.sv -----
module tb_circle_segment_intersect_test;

  localparam int COORD_BITS = 16;
  localparam int NUM_RANDOM = 1750;
  localparam int LATENCY = 7;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   chk;
    logic   hit;
    logic   degenerate;
  } seg_row_t;

  typedef struct {
    logic hit;
    logic degenerate;
  } isect_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [cseg_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  coord_t in_start_x, in_start_y, in_end_x, in_end_y;
  logic out_valid;
  logic out_ready;
  logic out_hit;
  logic out_degenerate;

  // Circle settings mirrored from the configuration writes.
  coord_t circ_cx, circ_cy;
  logic [COORD_BITS-2:0] circ_r;

  isect_t pending_isect[$];
  int mismatches;
  int segs_sent;
  int results_seen;
  int hits_seen;
  int degens_seen;

  circle_segment_intersect_test #(.COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_degenerate(out_degenerate)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Exact integer intersection test for one segment against the current circle.
  function automatic isect_t segment_crosses_circle(coord_t sx, coord_t sy,
                                                    coord_t ex, coord_t ey);
    longint dx, dy, fx, fy, gx, gy, rr, a, h, c0, c1;
    logic signed [129:0] hsq, prod;
    isect_t res;
    dx = longint'(sx) - longint'(ex);
    dy = longint'(sy) - longint'(ey);
    fx = longint'(ex) - longint'(circ_cx);
    fy = longint'(ey) - longint'(circ_cy);
    gx = longint'(sx) - longint'(circ_cx);
    gy = longint'(sy) - longint'(circ_cy);
    rr = longint'(circ_r) * longint'(circ_r);
    a = dx * dx + dy * dy;
    h = fx * dx + fy * dy;
    c0 = fx * fx + fy * fy - rr;
    c1 = gx * gx + gy * gy - rr;
    res.hit = 1'b0;
    res.degenerate = 1'b0;
    if (a == 0) begin
      res.degenerate = 1'b1;
    end else if (c0 == 0 || c1 == 0) begin
      res.hit = 1'b1;
    end else if ((c0 < 0) != (c1 < 0)) begin
      res.hit = 1'b1;
    end else if (c0 > 0 && h <= 0 && -h <= a) begin
      // Both ends outside with the closest point inside the segment.
      hsq = 130'(h) * 130'(h);
      prod = 130'(a) * 130'(c0);
      res.hit = (hsq >= prod);
    end
    return res;
  endfunction

  task automatic write_circle_reg(logic [cseg_pkg::CFG_IDX_BITS-1:0] idx,
                                  logic [COORD_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cseg_pkg::CFG_CENTER_X: circ_cx = val;
      cseg_pkg::CFG_CENTER_Y: circ_cy = val;
      cseg_pkg::CFG_RADIUS:   circ_r = val[COORD_BITS-2:0];
      default: ;
    endcase
  endtask

  // Waits for the pipeline to drain before touching the circle registers.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_isect.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_circle(coord_t cx, coord_t cy, logic [COORD_BITS-2:0] r);
    drain_results();
    write_circle_reg(cseg_pkg::CFG_CENTER_X, cx);
    write_circle_reg(cseg_pkg::CFG_CENTER_Y, cy);
    write_circle_reg(cseg_pkg::CFG_RADIUS, {1'b0, r});
    cfg_valid <= 1'b0;
  endtask

  // Sends one segment transaction and queues its expected result.
  task automatic send_segment(seg_row_t row);
    isect_t exp_res;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= row.sx;
    in_start_y <= row.sy;
    in_end_x <= row.ex;
    in_end_y <= row.ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_res = segment_crosses_circle(row.sx, row.sy, row.ex, row.ey);
    if (row.chk && (exp_res.hit !== row.hit || exp_res.degenerate !== row.degenerate)) begin
      mismatches++;
      $display("Table row disagrees with predictor for segment %0d", segs_sent);
    end
    if (row.chk) begin
      exp_res.hit = row.hit;
      exp_res.degenerate = row.degenerate;
    end
    pending_isect.push_back(exp_res);
    segs_sent++;
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  // Receiver: random stall per transaction, compare against the oldest expectation.
  initial begin
    isect_t want;
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      results_seen++;
      if (out_hit === 1'b1) hits_seen++;
      if (out_degenerate === 1'b1) degens_seen++;
      if (pending_isect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: hit=%b degen=%b",
                                        out_hit, out_degenerate);
      end else begin
        want = pending_isect.pop_front();
        if (out_hit !== want.hit || out_degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d mismatch: expected hit=%b degen=%b, got hit=%b degen=%b",
                     results_seen, want.hit, want.degenerate, out_hit, out_degenerate);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    seg_row_t directed[$];
    seg_row_t row;
    int span;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    circ_cx = '0;
    circ_cy = '0;
    circ_r = '0;
    mismatches = 0;
    segs_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    degens_seen = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the circle is a point at the origin.
    directed.push_back('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b0, 1'b1});
    directed.push_back('{-16'sd10, 16'sd0, 16'sd10, 16'sd0, 1'b1, 1'b1, 1'b0});
    directed.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1});
    directed.push_back('{16'sd1, 16'sd1, 16'sd2, 16'sd3, 1'b1, 1'b0, 1'b0});
    directed.push_back('{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 1'b0});
    directed.push_back('{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 1'b0});
    foreach (directed[i]) send_segment(directed[i]);

    // Circle of radius 100 at the origin.
    set_circle(16'sd0, 16'sd0, 15'd100);
    directed.delete();
    directed.push_back('{16'sd100, 16'sd0, 16'sd300, 16'sd0, 1'b1, 1'b1, 1'b0});
    directed.push_back('{16'sd10, 16'sd10, -16'sd10, 16'sd5, 1'b1, 1'b0, 1'b0});
    directed.push_back('{16'sd0, 16'sd0, 16'sd500, 16'sd0, 1'b1, 1'b1, 1'b0});
    directed.push_back('{-16'sd200, 16'sd100, 16'sd200, 16'sd100, 1'b1, 1'b1, 1'b0});
    directed.push_back('{-16'sd200, 16'sd101, 16'sd200, 16'sd101, 1'b1, 1'b0, 1'b0});
    directed.push_back('{-16'sd200, 16'sd0, 16'sd200, 16'sd0, 1'b1, 1'b1, 1'b0});
    directed.push_back('{16'sd200, 16'sd0, 16'sd300, 16'sd0, 1'b1, 1'b0, 1'b0});
    directed.push_back('{16'sd50, 16'sd50, 16'sd50, 16'sd50, 1'b1, 1'b0, 1'b1});
    foreach (directed[i]) send_segment(directed[i]);

    // Extreme settings: largest radius at the most negative corner, then a zero radius at the most positive corner.
    set_circle(-16'sd32768, -16'sd32768, 15'h7fff);
    directed.delete();
    directed.push_back('{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 1'b0});
    directed.push_back('{16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 1'b0});
    directed.push_back('{-16'sd1, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1, 1'b1, 1'b0});
    directed.push_back('{-16'sd32768, -16'sd32768, -16'sd32767, -16'sd32767, 1'b1, 1'b0, 1'b0});
    foreach (directed[i]) send_segment(directed[i]);
    set_circle(16'sd32767, 16'sd32767, 15'd0);
    directed.delete();
    directed.push_back('{16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0});
    directed.push_back('{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 1'b0});
    foreach (directed[i]) send_segment(directed[i]);

    // Random phases, each with a fresh circle set after a full drain.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase % 3)
        0: set_circle(rand_coord(0), rand_coord(0), 15'($urandom));
        1: set_circle(rand_coord(300), rand_coord(300), 15'($urandom_range(0, 400)));
        default: set_circle(rand_coord(3000), rand_coord(3000), 15'($urandom_range(0, 4000)));
      endcase
      for (int k = 0; k < NUM_RANDOM / 7; k++) begin
        span = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 700 : 7000);
        row.chk = 1'b0;
        row.hit = 1'b0;
        row.degenerate = 1'b0;
        // Mostly segments near the circle (full-range in every third phase), some full-range and some zero-length.
        if ($urandom_range(0, 9) == 0) begin
          row.sx = rand_coord(0);
          row.sy = rand_coord(0);
        end else begin
          row.sx = coord_t'(circ_cx + rand_coord(span));
          row.sy = coord_t'(circ_cy + rand_coord(span));
        end
        if ($urandom_range(0, 19) == 0) begin
          row.ex = row.sx;
          row.ey = row.sy;
        end else if ($urandom_range(0, 9) == 0) begin
          row.ex = rand_coord(0);
          row.ey = rand_coord(0);
        end else begin
          row.ex = coord_t'(circ_cx + rand_coord(span));
          row.ey = coord_t'(circ_cy + rand_coord(span));
        end
        send_segment(row);
      end
    end

    in_valid <= 1'b0;
    while (pending_isect.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d segments over several circle settings;", segs_sent);
    $display("%0d results, %0d hits, %0d degenerate.", results_seen, hits_seen, degens_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", pending_isect.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
